// ----- design/s2dec_pkg.sv -----
package s2dec_pkg;

    localparam int DEFAULT_VALUE_BITS = 32;
    localparam int CHAR_W             = 8;
    localparam int LENGTH_W           = 4;
    localparam int DIGIT_W            = 4;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
    localparam logic [DIGIT_W-1:0] BCD_LIMIT  = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJUST = 4'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic one_left;
        logic out_free;
        logic neg;
    } t_sts;

endpackage

// ----- design/signed_int_to_decimal_text.sv -----
// Converts a signed two's-complement integer into its decimal text, one ASCII
// character per output request, most significant digit first, with a leading
// '-' for negative values. The final character carries o_last and the total
// character count on o_length; every other character has o_length at zero.
// A request on the input channel is taken when i_valid is high and o_stall is
// low; a character leaves when o_valid is high and i_stall is low.
// The magnitude is converted by a bit-serial shift-and-add-three loop, one bit
// per cycle, through all VALUE_BITS bits. Leading zero digits are then dropped
// at one per cycle, after which one character is emitted per cycle while the
// receiver does not stall. The input stays stalled until the last character
// has been loaded into the output register, and a stalled output holds its
// character and pauses the emission. Reset empties the output register and
// returns the block to waiting for a request.
module signed_int_to_decimal_text import s2dec_pkg::*; #(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CHAR_W-1:0]     o_character,
    output logic                  o_last,
    output logic [LENGTH_W-1:0]   o_length
);

    t_cmd w_cmd;
    t_sts w_sts;

    s2dec_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    s2dec_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_stall     (i_stall),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_character (o_character),
        .o_last      (o_last),
        .o_length    (o_length)
    );

    a_len_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_length == '0))
        else $error("length set on a character that is not the last");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_character == CHAR_MINUS) |-> !o_last)
        else $error("minus sign flagged as the last character");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("new request taken while a conversion is under way");

endmodule

// ----- design/s2dec_ctrl.sv -----
module s2dec_ctrl import s2dec_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (i_sts.conv_done) begin
                    n_state = S_SKIP;
                end
            end
            S_SKIP: begin
                if (!i_sts.top_zero || i_sts.one_left) begin
                    n_state = i_sts.neg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free && i_sts.one_left) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
            end
            S_SKIP: begin
                o_cmd.skip = i_sts.top_zero && !i_sts.one_left;
            end
            S_SIGN: begin
                o_cmd.emit_sign = i_sts.out_free;
            end
            S_DIGIT: begin
                o_cmd.emit_digit = i_sts.out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

endmodule

// ----- design/s2dec_dp.sv -----
module s2dec_dp import s2dec_pkg::*; #(
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [VALUE_BITS-1:0]   i_value,
    input  logic                    i_stall,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic                    o_valid,
    output logic [CHAR_W-1:0]       o_character,
    output logic                    o_last,
    output logic [LENGTH_W-1:0]     o_length
);

    localparam int NDIG   = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
    localparam int BCD_W  = NDIG * DIGIT_W;
    localparam int BIT_W  = $clog2(VALUE_BITS);
    localparam int LEFT_W = $clog2(NDIG + 1);
    localparam int LEN_NW = $clog2(NDIG + 2);
    localparam int LEN_W  = (LEN_NW > LENGTH_W) ? LEN_NW : LENGTH_W;

    logic [VALUE_BITS-1:0] r_mag;
    logic [VALUE_BITS-1:0] n_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd;
    logic [BCD_W-1:0]      v_adj;
    logic [BIT_W-1:0]      r_bit;
    logic [BIT_W-1:0]      n_bit;
    logic [LEFT_W-1:0]     r_left;
    logic [LEFT_W-1:0]     n_left;
    logic [LEN_W-1:0]      r_len;
    logic [LEN_W-1:0]      n_len;
    logic                  r_neg;
    logic                  n_neg;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [CHAR_W-1:0]     r_char;
    logic [CHAR_W-1:0]     n_char;
    logic                  r_last;
    logic                  n_last;
    logic [LENGTH_W-1:0]   r_length;
    logic [LENGTH_W-1:0]   n_length;
    logic [DIGIT_W-1:0]    v_top;
    logic                  v_neg_in;
    logic                  v_out_free;

    assign v_top      = r_bcd[BCD_W-1 -: DIGIT_W];
    assign v_neg_in   = i_value[VALUE_BITS-1];
    assign v_out_free = !r_out_valid || !i_stall;

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            if (r_bcd[d*DIGIT_W +: DIGIT_W] >= BCD_LIMIT) begin
                v_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W] + BCD_ADJUST;
            end else begin
                v_adj[d*DIGIT_W +: DIGIT_W] = r_bcd[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_bit       = r_bit;
        n_left      = r_left;
        n_len       = r_len;
        n_neg       = r_neg;
        n_char      = r_char;
        n_last      = r_last;
        n_length    = r_length;
        n_out_valid = r_out_valid && i_stall;
        if (i_cmd.load) begin
            n_neg  = v_neg_in;
            n_mag  = v_neg_in ? (~i_value + VALUE_BITS'(1)) : i_value;
            n_bcd  = '0;
            n_bit  = '0;
            n_left = LEFT_W'(NDIG);
            n_len  = LEN_W'(NDIG) + LEN_W'(v_neg_in);
        end
        if (i_cmd.conv) begin
            n_bcd = {v_adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
            n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
            n_bit = r_bit + BIT_W'(1);
        end
        if (i_cmd.skip) begin
            n_bcd  = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            n_left = r_left - LEFT_W'(1);
            n_len  = r_len - LEN_W'(1);
        end
        if (i_cmd.emit_sign) begin
            n_out_valid = 1'b1;
            n_char      = CHAR_MINUS;
            n_last      = 1'b0;
            n_length    = '0;
        end
        if (i_cmd.emit_digit) begin
            n_out_valid = 1'b1;
            n_char      = CHAR_ZERO + CHAR_W'(v_top);
            n_last      = (r_left == LEFT_W'(1));
            n_length    = (r_left == LEFT_W'(1)) ? r_len[LENGTH_W-1:0] : '0;
            n_bcd       = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            n_left      = r_left - LEFT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_bcd    <= n_bcd;
        r_bit    <= n_bit;
        r_left   <= n_left;
        r_len    <= n_len;
        r_neg    <= n_neg;
        r_char   <= n_char;
        r_last   <= n_last;
        r_length <= n_length;
    end

    assign o_sts.conv_done = (r_bit == BIT_W'(VALUE_BITS - 1));
    assign o_sts.top_zero  = (v_top == '0);
    assign o_sts.one_left  = (r_left == LEFT_W'(1));
    assign o_sts.out_free  = v_out_free;
    assign o_sts.neg       = r_neg;

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_length    = r_length;

endmodule
